// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/sfao_pkg.sv -----
`default_nettype none
package sfao_pkg;

   localparam int ANGLE_BITS_DEF      = 16;
   localparam int ATAN_ITERATIONS_DEF = 16;
   localparam int ATAN_TABLE_LEN      = 24;

   localparam logic [2:0] REG_RESISTANCE     = 3'd0;
   localparam logic [2:0] REG_INDUCTANCE     = 3'd1;
   localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd2;
   localparam logic [2:0] REG_ADAPT_GAIN     = 3'd3;
   localparam logic [2:0] REG_LIMIT_MAX      = 3'd4;
   localparam logic [2:0] REG_LIMIT_MIN      = 3'd5;
   localparam logic [2:0] REG_CENTERING_MODE = 3'd6;
   localparam logic [2:0] REG_CENTERING_GAIN = 3'd7;

   localparam logic [1:0] MODE_NONE      = 2'd0;
   localparam logic [1:0] MODE_NONLINEAR = 2'd1;
   localparam logic [1:0] MODE_CLAMP     = 2'd2;

   localparam int DIGIT = 4;   // bits of the serial multiplier operand per cycle

   typedef struct packed {
      logic [15:0] resistance;
      logic [15:0] inductance;
      logic [15:0] sample_period;
      logic [15:0] adapt_gain;
      logic [15:0] limit_max;
      logic [15:0] limit_min;
      logic [1:0]  centering_mode;
      logic [15:0] centering_gain;
   } cfg_type;

   // handshake between sequencer and the shared serial multiplier
   typedef struct packed {
      logic start;
      logic busy;
   } mul_ctl_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] k);
      logic [31:0] t;
      begin
         unique case (k)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            default: t = 32'h0;
         endcase
         return t;
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sfao_mul.sv -----
`default_nettype none
// Signed 40 x signed 34 multiplier, multiplier operand taken a digit per cycle.
module sfao_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sfao_pkg::mul_ctl_type ctl_in,
   input  wire logic signed [39:0]  a,
   input  wire logic signed [33:0]  b,
   output logic                     done,
   output logic signed [73:0]       product
);
   localparam int D     = sfao_pkg::DIGIT;
   localparam int STEPS = 36 / D;

   logic signed [73:0] acc_ff, acc_in;
   logic signed [73:0] mcand_ff, mcand_in;
   logic [35:0]        mplier_ff, mplier_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic signed [73:0] partial;
   logic               last;

   assign last = (cnt_ff == 4'(STEPS - 1));

   always_comb begin
      // top digit carries the sign of the multiplier
      if (last)
         partial = mcand_ff * $signed({{70{mplier_ff[D-1]}}, mplier_ff[D-1:0]});
      else
         partial = mcand_ff * $signed({70'd0, mplier_ff[D-1:0]});
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (ctl_in.start) begin
         acc_in    = '0;
         mcand_in  = 74'(a);
         mplier_in = 36'(b);
         cnt_in    = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         acc_in    = acc_ff + partial;
         mcand_in  = mcand_ff <<< D;
         mplier_in = mplier_ff >> D;
         cnt_in    = cnt_ff + 4'd1;
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ----- rtl/core/sfao_cordic.sv -----
`default_nettype none
// Vectoring CORDIC, one iteration per cycle.
module sfao_cordic #(
   parameter int ANGLE_BITS      = sfao_pkg::ANGLE_BITS_DEF,
   parameter int ATAN_ITERATIONS = sfao_pkg::ATAN_ITERATIONS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] fa,
   input  wire logic signed [31:0] fb,
   output logic                    done,
   output logic [15:0]             angle
);
   localparam int ITERS = (ATAN_ITERATIONS < sfao_pkg::ATAN_TABLE_LEN)
                          ? ATAN_ITERATIONS : sfao_pkg::ATAN_TABLE_LEN;

   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        z_ff, z_in;
   logic [4:0]         k_ff, k_in;
   logic               run_ff, run_in, done_ff, done_in;
   logic               zero_ff, zero_in;
   logic signed [35:0] dx, dy;
   logic [31:0]        zr;

   assign dx = y_ff >>> k_ff;
   assign dy = x_ff >>> k_ff;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; k_in = k_ff;
      run_in = run_ff; done_in = 1'b0; zero_in = zero_ff;
      if (start) begin
         zero_in = (fa == 32'sd0) && (fb == 32'sd0);
         k_in    = '0;
         run_in  = 1'b1;
         if (fa < 0) begin
            x_in = -36'(fa); y_in = -36'(fb); z_in = 32'h80000000;
         end else begin
            x_in = 36'(fa);  y_in = 36'(fb);  z_in = '0;
         end
      end else if (run_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + sfao_pkg::atan_turn(k_ff);
         end else begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - sfao_pkg::atan_turn(k_ff);
         end
         k_in = k_ff + 5'd1;
         if (k_ff == 5'(ITERS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; k_ff <= k_in; zero_ff <= zero_in;
   end

   always_comb begin
      zr = (z_ff + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
      angle = zero_ff ? 16'd0 : 16'(zr << (16 - ANGLE_BITS));
   end
   assign done = done_ff;
endmodule
`default_nettype wire

// ----- rtl/core/sfao_seq.sv -----
`default_nettype none
// Step sequencer: each product goes through the shared serial multiplier.
module sfao_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfao_pkg::cfg_type    cfg,
   input  wire logic                 go,
   input  wire logic signed [15:0]   va, vb, ia, ib,
   output logic                      finished,
   output logic signed [31:0]        flux_a,
   output logic signed [31:0]        flux_b,
   output logic [15:0]               limit,
   output sfao_pkg::mul_ctl_type     mul_ctl,
   output logic signed [39:0]        mul_a,
   output logic signed [33:0]        mul_b,
   input  wire logic                 mul_done,
   input  wire logic signed [73:0]   mul_p
);
   typedef enum logic [14:0] {
      S_IDLE = 15'b000000000000001,
      S_SQA  = 15'b000000000000010,
      S_SQB  = 15'b000000000000100,
      S_LSQ  = 15'b000000000001000,
      S_ADP  = 15'b000000000010000,
      S_RI   = 15'b000000000100000,
      S_TS   = 15'b000000001000000,
      S_LI   = 15'b000000010000000,
      S_AXS  = 15'b000000100000000,
      S_CSA  = 15'b000001000000000,
      S_CSB  = 15'b000010000000000,
      S_EA   = 15'b000100000000000,
      S_GA   = 15'b001000000000000,
      S_FIN  = 15'b010000000000000,
      S_LSQ2 = 15'b100000000000000
   } state_type;

   state_type           st_ff, st_in;
   logic                issued_ff, issued_in;
   logic                axis_ff, axis_in;   // 0 alpha, 1 beta
   logic signed [31:0]  fa_ff, fa_in, fb_ff, fb_in;
   logic [15:0]         lim_ff, lim_in;
   logic signed [15:0]  pia_ff, pia_in, pib_ff, pib_in;
   logic signed [73:0]  t0_ff, t0_in, t1_ff, t1_in;   // scratch
   logic signed [39:0]  ea_ff, ea_in;                // e rounded
   logic                done_ff, done_in;

   logic signed [15:0]  cur_v, cur_i, cur_pi;
   logic signed [31:0]  cur_f;
   logic signed [73:0]  rnd, nl, sum;
   logic signed [31:0]  cl;
   logic signed [33:0]  clp;

   assign cur_v  = axis_ff ? vb : va;
   assign cur_i  = axis_ff ? ib : ia;
   assign cur_pi = axis_ff ? pib_ff : pia_ff;
   assign cur_f  = axis_ff ? fb_ff : fa_ff;

   function automatic logic signed [73:0] sat(input logic signed [73:0] x);
      if (x > 74'sh7FFFFFFF) return 74'sh7FFFFFFF;
      if (x < -74'sh80000000) return -74'sh80000000;
      return x;
   endfunction

   always_comb begin
      st_in = st_ff; issued_in = issued_ff; axis_in = axis_ff;
      fa_in = fa_ff; fb_in = fb_ff; lim_in = lim_ff;
      pia_in = pia_ff; pib_in = pib_ff;
      t0_in = t0_ff; t1_in = t1_ff; ea_in = ea_ff; done_in = 1'b0;
      mul_ctl = '0; mul_a = '0; mul_b = '0;
      rnd = '0; nl = '0; sum = '0;
      clp = $signed({3'b000, lim_ff, 15'd0});
      cl  = 32'(clp);
      if (st_ff != S_IDLE && st_ff != S_FIN && st_ff != S_AXS && !issued_ff) begin
         mul_ctl.start = 1'b1;
         issued_in     = 1'b1;
      end
      unique case (st_ff)
         S_IDLE: if (go) begin st_in = S_SQA; issued_in = 1'b0; axis_in = 1'b0; end
         S_SQA: begin
            mul_a = 40'(fa_ff); mul_b = 34'(fa_ff);
            if (mul_done) begin t0_in = mul_p; st_in = S_SQB; issued_in = 1'b0; end
         end
         S_SQB: begin
            mul_a = 40'(fb_ff); mul_b = 34'(fb_ff);
            if (mul_done) begin
               // |f|^2 in Q30
               t0_in = (t0_ff + mul_p) >>> 30;
               issued_in = 1'b0;
               st_in = (axis_ff) ? S_LSQ2 : S_LSQ;
            end
         end
         S_LSQ: begin
            mul_a = $signed({24'd0, lim_ff}); mul_b = $signed({18'd0, lim_ff});
            if (mul_done) begin t1_in = t0_ff - mul_p; st_in = S_ADP; issued_in = 1'b0; end
         end
         S_ADP: begin
            mul_a = 40'(t1_ff); mul_b = $signed({18'd0, cfg.adapt_gain});
            if (mul_done) begin
               rnd = (mul_p + (74'sd1 <<< 30)) >>> 31;
               nl  = $signed({58'd0, lim_ff}) + rnd;
               if (nl > $signed({58'd0, cfg.limit_max})) nl = $signed({58'd0, cfg.limit_max});
               if (nl < $signed({58'd0, cfg.limit_min})) nl = $signed({58'd0, cfg.limit_min});
               lim_in = 16'(nl);
               st_in = S_RI; issued_in = 1'b0; axis_in = 1'b0;
            end
         end
         S_RI: begin
            mul_a = $signed({24'd0, cfg.resistance}); mul_b = 34'(cur_i);
            if (mul_done) begin
               t0_in = $signed({{46{cur_v[15]}}, cur_v, 12'd0}) - mul_p;
               st_in = S_TS; issued_in = 1'b0;
            end
         end
         S_TS: begin
            mul_a = 40'(t0_ff); mul_b = $signed({18'd0, cfg.sample_period});
            if (mul_done) begin t1_in = (mul_p + 74'sd32) >>> 6; st_in = S_LI; issued_in = 1'b0; end
         end
         S_LI: begin
            mul_a = $signed({24'd0, cfg.inductance});
            mul_b = 34'(17'(cur_i) - 17'(cur_pi));
            if (mul_done) begin
               sum = sat(74'(cur_f) + t1_ff - (mul_p <<< 6));
               if (axis_ff) begin fb_in = 32'(sum); pib_in = ib; end
               else         begin fa_in = 32'(sum); pia_in = ia; end
               issued_in = 1'b0;
               if (!axis_ff) begin axis_in = 1'b1; st_in = S_RI; end
               else st_in = S_AXS;
            end
         end
         S_AXS: begin
            issued_in = 1'b1;
            axis_in = 1'b0;
            if (cfg.centering_mode == sfao_pkg::MODE_CLAMP) begin
               if (fa_ff > cl) fa_in = cl; else if (fa_ff < -cl) fa_in = -cl;
               if (fb_ff > cl) fb_in = cl; else if (fb_ff < -cl) fb_in = -cl;
               st_in = S_FIN;
            end else if (cfg.centering_mode == sfao_pkg::MODE_NONLINEAR) begin
               st_in = S_CSA; issued_in = 1'b0;
            end else st_in = S_FIN;
         end
         S_CSA: begin
            mul_a = 40'(fa_ff); mul_b = 34'(fa_ff);
            if (mul_done) begin t0_in = mul_p; st_in = S_CSB; issued_in = 1'b0; end
         end
         S_CSB: begin
            mul_a = 40'(fb_ff); mul_b = 34'(fb_ff);
            if (mul_done) begin
               t0_in = (t0_ff + mul_p) >>> 30;
               st_in = S_LSQ2; axis_in = 1'b1; issued_in = 1'b0;
            end
         end
         S_LSQ2: begin
            mul_a = $signed({24'd0, lim_ff}); mul_b = $signed({18'd0, lim_ff});
            if (mul_done) begin
               ea_in = 40'((mul_p - t0_ff + 74'sd16384) >>> 15);
               st_in = S_EA; axis_in = 1'b0; issued_in = 1'b0;
            end
         end
         S_EA: begin
            mul_a = ea_ff; mul_b = 34'(cur_f);
            if (mul_done) begin
               t1_in = (mul_p + 74'sd16384) >>> 15;
               st_in = S_GA; issued_in = 1'b0;
            end
         end
         S_GA: begin
            mul_a = 40'(t1_ff); mul_b = $signed({18'd0, cfg.centering_gain});
            if (mul_done) begin
               sum = sat(74'(cur_f) + ((mul_p + 74'sd32768) >>> 16));
               if (axis_ff) begin fb_in = 32'(sum); st_in = S_FIN; end
               else begin fa_in = 32'(sum); axis_in = 1'b1; st_in = S_EA; end
               issued_in = 1'b0;
            end
         end
         S_FIN: begin done_in = 1'b1; st_in = S_IDLE; issued_in = 1'b0; end
         default: st_in = S_IDLE;
      endcase
   end

   // S_EA for beta reads no alpha value, so no uncentered alpha is held aside
   // (beta term uses fb_ff, alpha already updated but only fb_ff is read)

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; issued_ff <= 1'b0; done_ff <= 1'b0;
         fa_ff <= '0; fb_ff <= '0; lim_ff <= '0; pia_ff <= '0; pib_ff <= '0;
         axis_ff <= 1'b0;
      end else begin
         st_ff <= st_in; issued_ff <= issued_in; done_ff <= done_in;
         fa_ff <= fa_in; fb_ff <= fb_in; lim_ff <= lim_in;
         pia_ff <= pia_in; pib_ff <= pib_in; axis_ff <= axis_in;
      end
      t0_ff <= t0_in; t1_ff <= t1_in; ea_ff <= ea_in;
   end

   assign finished = done_ff;
   assign flux_a   = fa_ff;
   assign flux_b   = fb_ff;
   assign limit    = lim_ff;
endmodule
`default_nettype wire

// ----- rtl/core/sensorless_flux_angle_observer.sv -----
`default_nettype none
// Channel  Direction  Handshake           Payload
// req      in         req_tvalid/tready   tdata 64b, tuser injecting
// rsp      out        rsp_tvalid/tready   tdata 96b, tuser angle_updated
// csr      in         csr_wen             csr_index 3b, csr_wdata 16b
// One transaction at a time; each product goes through the shared 40x34 multiplier
// (start, nine 4-bit digit steps, handoff), ten products per sample.
// rsp_tvalid rises when the sequencer finishes if injecting, else once the CORDIC
// has recomputed the angle; nonlinear centering adds seven more products.
// Reset is synchronous and clears control state and configuration; no clearing pass.
// A held result stalls intake until rsp is taken; intake reopens the next cycle.
module sensorless_flux_angle_observer #(
   parameter int ANGLE_BITS      = sfao_pkg::ANGLE_BITS_DEF,
   parameter int ATAN_ITERATIONS = sfao_pkg::ATAN_ITERATIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // v_alpha, v_beta, i_alpha, i_beta
   input  wire logic        req_tuser,  // injecting
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,  // rotor_angle, flux_alpha_out, flux_beta_out, flux_limit_out
   output logic             rsp_tuser,  // angle_updated
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   sfao_pkg::cfg_type     cfg_ff;
   sfao_pkg::mul_ctl_type mul_ctl;
   logic signed [39:0]    mul_a;
   logic signed [33:0]    mul_b;
   logic                  mul_done;
   logic signed [73:0]    mul_p;
   logic [63:0]           din_ff;
   logic                  inj_ff;
   logic                  busy_ff, busy_in;
   logic                  seq_go, seq_fin, cor_done;
   logic signed [31:0]    fa, fb;
   logic [15:0]           lim, angle, last_ff;
   logic                  vld_ff;
   logic [95:0]           out_ff;
   logic                  upd_ff;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.resistance     <= '0;
         cfg_ff.inductance     <= '0;
         cfg_ff.sample_period  <= '0;
         cfg_ff.adapt_gain     <= '0;
         cfg_ff.limit_max      <= 16'hFFFF;
         cfg_ff.limit_min      <= '0;
         cfg_ff.centering_mode <= sfao_pkg::MODE_CLAMP;
         cfg_ff.centering_gain <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            sfao_pkg::REG_RESISTANCE:     cfg_ff.resistance     <= csr_wdata;
            sfao_pkg::REG_INDUCTANCE:     cfg_ff.inductance     <= csr_wdata;
            sfao_pkg::REG_SAMPLE_PERIOD:  cfg_ff.sample_period  <= csr_wdata;
            sfao_pkg::REG_ADAPT_GAIN:     cfg_ff.adapt_gain     <= csr_wdata;
            sfao_pkg::REG_LIMIT_MAX:      cfg_ff.limit_max      <= csr_wdata;
            sfao_pkg::REG_LIMIT_MIN:      cfg_ff.limit_min      <= csr_wdata;
            sfao_pkg::REG_CENTERING_MODE: cfg_ff.centering_mode <= csr_wdata[1:0];
            sfao_pkg::REG_CENTERING_GAIN: cfg_ff.centering_gain <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !busy_ff && !vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign seq_go     = accept;

   always_comb begin
      busy_in = busy_ff;
      if (accept) busy_in = 1'b1;
      else if ((seq_fin && inj_ff) || cor_done) busy_in = 1'b0;
   end

   sfao_mul u_mul (
      .clock, .reset, .ctl_in(mul_ctl), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   sfao_seq u_seq (
      .clock, .reset, .cfg(cfg_ff), .go(seq_go),
      .va(din_ff[15:0]), .vb(din_ff[31:16]),
      .ia(din_ff[47:32]), .ib(din_ff[63:48]),
      .finished(seq_fin), .flux_a(fa), .flux_b(fb), .limit(lim),
      .mul_ctl, .mul_a, .mul_b, .mul_done, .mul_p
   );

   sfao_cordic #(.ANGLE_BITS(ANGLE_BITS), .ATAN_ITERATIONS(ATAN_ITERATIONS)) u_cordic (
      .clock, .reset, .start(seq_fin && !inj_ff), .fa, .fb,
      .done(cor_done), .angle
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; vld_ff <= 1'b0; last_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         if (rsp_tvalid && rsp_tready) vld_ff <= 1'b0;
         if (seq_fin && inj_ff) vld_ff <= 1'b1;
         if (cor_done) begin vld_ff <= 1'b1; last_ff <= angle; end
      end
      if (accept) begin din_ff <= req_tdata; inj_ff <= req_tuser; end
      if (seq_fin && inj_ff) begin out_ff <= {lim, fb, fa, last_ff}; upd_ff <= 1'b0; end
      if (cor_done) begin out_ff <= {lim, fb, fa, angle}; upd_ff <= 1'b1; end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = upd_ff;
endmodule
`default_nettype wire

// ----- rtl/core/sfao_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module sfao_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        rsp_tuser
);
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")
   `ASSERT_CLK(a_one_at_a_time, clock, reset, rsp_tvalid |-> !req_tready, "intake during result")
   `ASSERT_CLK(a_accept_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "double intake")
   `ASSERT_CLK(a_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed")
endmodule
bind sensorless_flux_angle_observer sfao_checker u_sfao_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);
`default_nettype wire
